// ----- rtl/mse_pkg.sv -----
// Shared types, constants and helper functions of the momentum scroll engine.
package mse_pkg;

  localparam int HIST_DEPTH = 16;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);
  localparam int HIST_W     = 96;
  localparam int DIV_STEPS  = 64;
  localparam int DIV_CW     = $clog2(DIV_STEPS);
  localparam int ACC_W      = 51 + HIST_CW;
  localparam int TW_W       = 18 + HIST_CW;

  localparam logic [1:0] OP_SCROLL = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_LOST   = 2'd2;

  localparam logic [2:0] KIND_PASS     = 3'd0;
  localparam logic [2:0] KIND_BEGAN    = 3'd1;
  localparam logic [2:0] KIND_ACTIVE   = 3'd2;
  localparam logic [2:0] KIND_ENDED    = 3'd3;
  localparam logic [2:0] KIND_CANCELED = 3'd4;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_GESTURE = 2'd1;
  localparam logic [1:0] PH_COAST   = 2'd2;

  localparam logic [1:0] CFG_FRICTION  = 2'd0;
  localparam logic [1:0] CFG_MIN_SPEED = 2'd1;
  localparam logic [1:0] CFG_MAX_SPEED = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd3;

  localparam logic [31:0]        TRIM_US    = 32'd150000;
  localparam logic [31:0]        MIN_LEN_US = 32'd2000;
  localparam logic signed [31:0] MIN_TRAVEL = 32'sd2560;
  localparam logic [16:0]        FRIC_ONE   = 17'd65536;

  localparam logic [16:0] FRIC_RESET      = 17'd62915;
  localparam logic [30:0] MIN_SPEED_RESET = 31'd128;
  localparam logic [30:0] MAX_SPEED_RESET = 31'd25600;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        time_us;
    logic signed [31:0] raw_dx;
    logic signed [31:0] raw_dy;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic               stopped;
    logic               finger_based;
    logic               high_res;
    logic [7:0]         window_tag;
    logic               focused;
    logic [7:0]         mod_keys;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] scaled_x;
    logic signed [31:0] scaled_y;
    logic [7:0]         target_window;
    logic [7:0]         out_mods;
    logic               ticks_wanted;
    logic               last;
  } out_word_t;

  // Saturate a wide signed value to the int32 range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Divide a Q16 product by 65536, truncating toward zero.
  function automatic logic signed [65:0] trunc_q16(input logic signed [65:0] p);
    logic signed [65:0] q;
    q = p >>> 16;
    if (p[65] && (p[15:0] != 16'h0)) q = q + 66'sd1;
    return q;
  endfunction

  function automatic logic [HIST_AW-1:0] ring_inc(input logic [HIST_AW-1:0] idx);
    if (idx == HIST_AW'(HIST_DEPTH - 1)) return '0;
    return idx + 1'b1;
  endfunction

  function automatic logic [HIST_AW-1:0] ring_dec(input logic [HIST_AW-1:0] idx);
    if (idx == '0) return HIST_AW'(HIST_DEPTH - 1);
    return idx - 1'b1;
  endfunction

endpackage

// ----- rtl/mse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/momentum_scroll_engine_core.sv -----
// Momentum scroll engine: gesture tracking, coast start and per-tick friction decay.
//
// The engine watches finger scroll events, animation ticks and window-loss
// notices, one word at a time on a valid/ready input channel, and answers
// with zero, one or two result words on a valid/ready output channel; the
// last word of each input carries the last flag. All motion values are Q23.8,
// friction is Q1.16 and the event scale is a Q15.16 ratio. A single shared
// sequencer does the work, so in_ready is high only while it is idle, and a
// finished result waits in the output register without holding up the next
// input. A finger event with a positive delta takes its event scale from a
// one-bit-per-cycle restoring divider with a 64-bit quotient; without a
// positive delta it skips the divider. A finger lift that starts a coast
// trims old samples and then runs one weight division per kept sample plus
// two for the averages through the same divider. A pending cancel word adds
// an emit step, and a result that the receiver holds off stalls the sequencer.
// The sample history lives in one RAM, read one entry per cycle.
// Configuration writes take effect at once and are expected only while the
// engine is idle.
module momentum_scroll_engine_core
  import mse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_DISPATCH   = 5'd1;
  localparam logic [4:0] S_PREP       = 5'd2;
  localparam logic [4:0] S_SCALE      = 5'd3;
  localparam logic [4:0] S_SCALE_SET  = 5'd4;
  localparam logic [4:0] S_DIV        = 5'd5;
  localparam logic [4:0] S_REV        = 5'd6;
  localparam logic [4:0] S_TRIM       = 5'd7;
  localparam logic [4:0] S_TRIM_CHK   = 5'd8;
  localparam logic [4:0] S_SPAN       = 5'd9;
  localparam logic [4:0] S_W_RD       = 5'd10;
  localparam logic [4:0] S_W_MX       = 5'd11;
  localparam logic [4:0] S_W_MY       = 5'd12;
  localparam logic [4:0] S_W_ACC      = 5'd13;
  localparam logic [4:0] S_VX         = 5'd14;
  localparam logic [4:0] S_VY         = 5'd15;
  localparam logic [4:0] S_VDONE      = 5'd16;
  localparam logic [4:0] S_DECAY_X    = 5'd17;
  localparam logic [4:0] S_DECAY_Y    = 5'd18;
  localparam logic [4:0] S_DECAY_DONE = 5'd19;
  localparam logic [4:0] S_SC_Y       = 5'd20;
  localparam logic [4:0] S_SC_DONE    = 5'd21;
  localparam logic [4:0] S_CANCEL     = 5'd22;
  localparam logic [4:0] S_EMIT       = 5'd23;

  // Configuration registers.
  logic [16:0] fric_r;
  logic [30:0] min_r;
  logic [30:0] max_r;
  logic [19:0] tmo_r;

  // Sequencer and engine state.
  logic [4:0]                state_r, state_nxt;
  logic [4:0]                ret_r, ret_nxt;
  in_word_t                  in_r, in_nxt;
  logic [1:0]                phase_r, phase_nxt;
  logic [HIST_AW-1:0]        head_r, head_nxt;
  logic [HIST_AW-1:0]        tail_r, tail_nxt;
  logic [HIST_CW-1:0]        count_r, count_nxt;
  logic signed [31:0]        vel_x_r, vel_x_nxt;
  logic signed [31:0]        vel_y_r, vel_y_nxt;
  logic signed [31:0]        scale_r, scale_nxt;
  logic [7:0]                owner_r, owner_nxt;
  logic [7:0]                mods_r, mods_nxt;
  logic [31:0]               gstart_r, gstart_nxt;
  logic [31:0]               glen_r, glen_nxt;
  logic signed [31:0]        trav_x_r, trav_x_nxt;
  logic signed [31:0]        trav_y_r, trav_y_nxt;
  logic [31:0]               now_r, now_nxt;
  logic [HIST_AW-1:0]        addr_r, addr_nxt;
  logic [31:0]               first_r, first_nxt;
  logic [31:0]               span_r, span_nxt;
  logic [HIST_AW-1:0]        idx_r, idx_nxt;
  logic [HIST_CW-1:0]        cnt_r, cnt_nxt;
  logic [17:0]               w_r, w_nxt;
  logic signed [ACC_W-1:0]   acc_x_r, acc_x_nxt;
  logic signed [ACC_W-1:0]   acc_y_r, acc_y_nxt;
  logic [TW_W-1:0]           tw_r, tw_nxt;
  logic                      start_r, start_nxt;
  logic signed [31:0]        sx_r, sx_nxt;
  out_word_t                 pend_r, pend_nxt;

  // Shared divider.
  logic [63:0]               div_q_r, div_q_nxt;
  logic [32:0]               div_rem_r, div_rem_nxt;
  logic [31:0]               div_d_r, div_d_nxt;
  logic [DIV_CW-1:0]         div_cnt_r, div_cnt_nxt;
  logic                      div_neg_r, div_neg_nxt;
  logic [4:0]                div_ret_r, div_ret_nxt;
  logic                      go_div;
  logic signed [63:0]        div_num;
  logic [31:0]               div_den;
  logic [32:0]               rem_sh;
  logic                      rem_ge;
  logic signed [65:0]        div_res;
  logic signed [31:0]        div_sat;

  // Shared multiplier with a registered product.
  logic signed [32:0]        mul_a, mul_b;
  logic signed [65:0]        prod_r;

  // Output register.
  logic                      out_valid_r;
  out_word_t                 out_data_r;
  logic                      out_load;

  // History RAM port.
  logic                      ram_we;
  logic [HIST_W-1:0]         ram_wdata;
  logic [HIST_W-1:0]         ram_rdata;
  logic signed [31:0]        rd_dx, rd_dy;
  logic [31:0]               rd_t;

  // Helpers.
  logic                      synth;
  logic [31:0]               now_c;
  logic                      pass_thru;
  logic                      win_clash;
  logic                      reversal;
  logic                      coast_ok;
  logic signed [31:0]        abs_x, abs_y, abs_m;
  logic [HIST_CW-1:0]        cnt_v;
  logic [HIST_AW-1:0]        head_v;
  logic [31:0]               age, dspan, sd;
  logic [17:0]               w_c;
  logic                      ended;
  logic signed [31:0]        sy_c;
  logic [16:0]               fric_eff;
  out_word_t                 pass_word, cancel_word;

  function automatic logic signed [31:0] merge_axis(input logic signed [31:0] v,
                                                   input logic signed [31:0] x,
                                                   input logic [30:0]        mx);
    logic signed [32:0] r;
    logic signed [32:0] lim;
    lim = {2'b00, mx};
    if (x == 32'sd0 || !((x > 32'sd0 && v < 32'sd0) || (x < 32'sd0 && v > 32'sd0))) begin
      r = 33'(v) + 33'(x);
    end else begin
      r = 33'(x);
    end
    if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] decay_axis(input logic signed [65:0] p,
                                                   input logic [30:0]        mn);
    logic signed [65:0] r;
    logic signed [65:0] mag;
    r = trunc_q16(p);
    mag = r[65] ? -r : r;
    if (mag < {35'b0, mn}) return 32'sd0;
    return r[31:0];
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_dx = ram_rdata[31:0];
  assign rd_dy = ram_rdata[63:32];
  assign rd_t  = ram_rdata[95:64];

  assign synth     = in_r.stopped && (tmo_r != 20'd0);
  assign now_c     = in_r.time_us - (synth ? {12'b0, tmo_r} : 32'd0);
  assign pass_thru = !in_r.finger_based || !in_r.high_res || (fric_r >= FRIC_ONE);
  assign win_clash = (owner_r != 8'd0) && (owner_r != in_r.window_tag);
  assign fric_eff  = (fric_r > FRIC_ONE) ? FRIC_ONE : fric_r;

  // A reversal compares the newest stored delta against the new offsets.
  assign reversal = !synth && (count_r != '0) &&
                    ((rd_dx > 32'sd0 && in_r.offset_x < 32'sd0) ||
                     (rd_dx < 32'sd0 && in_r.offset_x > 32'sd0) ||
                     (rd_dy > 32'sd0 && in_r.offset_y < 32'sd0) ||
                     (rd_dy < 32'sd0 && in_r.offset_y > 32'sd0));

  assign abs_x = trav_x_r[31] ? ((trav_x_r == 32'sh80000000) ? 32'sh7FFFFFFF : -trav_x_r)
                              : trav_x_r;
  assign abs_y = trav_y_r[31] ? ((trav_y_r == 32'sh80000000) ? 32'sh7FFFFFFF : -trav_y_r)
                              : trav_y_r;
  assign abs_m    = (abs_x > abs_y) ? abs_x : abs_y;
  assign coast_ok = (abs_m > MIN_TRAVEL) && (glen_r > MIN_LEN_US);

  assign age   = now_r - rd_t;
  assign dspan = rd_t - first_r;
  assign sd    = ((rd_t - first_r) > span_r) ? span_r : (rd_t - first_r);
  assign w_c   = 18'd65536 + {1'b0, div_q_r[16:0]};
  assign ended = !start_r && (vel_x_r == 32'sd0) && (vel_y_r == 32'sd0);
  assign sy_c  = sat32(trunc_q16(prod_r));

  assign rem_sh  = {div_rem_r[31:0], div_q_r[63]};
  assign rem_ge  = (rem_sh >= {1'b0, div_d_r});
  assign div_res = div_neg_r ? -$signed({2'b00, div_q_r}) : $signed({2'b00, div_q_r});
  assign div_sat = sat32(div_res);

  assign ram_wdata = {now_r, in_r.raw_dy, in_r.raw_dx};

  always_comb begin
    pass_word               = '0;
    pass_word.kind          = KIND_PASS;
    pass_word.vel_x         = in_r.raw_dx;
    pass_word.vel_y         = in_r.raw_dy;
    pass_word.scaled_x      = in_r.offset_x;
    pass_word.scaled_y      = in_r.offset_y;
    pass_word.target_window = in_r.window_tag;
    pass_word.out_mods      = in_r.mod_keys;
    pass_word.ticks_wanted  = (phase_r == PH_COAST);
    pass_word.last          = 1'b1;

    cancel_word               = '0;
    cancel_word.kind          = KIND_CANCELED;
    cancel_word.target_window = owner_r;
    cancel_word.out_mods      = mods_r;
    cancel_word.last          = 1'b1;
  end

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    in_nxt      = in_r;
    phase_nxt   = phase_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    vel_x_nxt   = vel_x_r;
    vel_y_nxt   = vel_y_r;
    scale_nxt   = scale_r;
    owner_nxt   = owner_r;
    mods_nxt    = mods_r;
    gstart_nxt  = gstart_r;
    glen_nxt    = glen_r;
    trav_x_nxt  = trav_x_r;
    trav_y_nxt  = trav_y_r;
    now_nxt     = now_r;
    addr_nxt    = addr_r;
    first_nxt   = first_r;
    span_nxt    = span_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    w_nxt       = w_r;
    acc_x_nxt   = acc_x_r;
    acc_y_nxt   = acc_y_r;
    tw_nxt      = tw_r;
    start_nxt   = start_r;
    sx_nxt      = sx_r;
    pend_nxt    = pend_r;
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    div_d_nxt   = div_d_r;
    div_cnt_nxt = div_cnt_r;
    div_neg_nxt = div_neg_r;
    div_ret_nxt = div_ret_r;
    go_div      = 1'b0;
    div_num     = '0;
    div_den     = '0;
    mul_a       = '0;
    mul_b       = '0;
    ram_we      = 1'b0;
    out_load    = 1'b0;
    cnt_v       = count_r;
    head_v      = head_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (in_r.op)
          OP_LOST: state_nxt = S_CANCEL;
          OP_TICK: begin
            start_nxt = 1'b0;
            if (phase_r != PH_COAST) state_nxt = S_IDLE;
            else if (in_r.focused) state_nxt = S_DECAY_X;
            else state_nxt = S_CANCEL;
          end
          OP_SCROLL: begin
            if (pass_thru) begin
              pend_nxt  = pass_word;
              ret_nxt   = S_IDLE;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_PREP;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      // Gesture bookkeeping and the window/phase cancel rules.
      S_PREP: begin
        now_nxt = now_c;
        if (phase_r == PH_GESTURE) begin
          trav_x_nxt = sat32(66'(33'(trav_x_r) + 33'(in_r.raw_dx)));
          trav_y_nxt = sat32(66'(33'(trav_y_r) + 33'(in_r.raw_dy)));
          if (in_r.stopped) begin
            glen_nxt   = now_c - gstart_r;
            gstart_nxt = '0;
          end
        end else begin
          trav_x_nxt = '0;
          trav_y_nxt = '0;
          glen_nxt   = '0;
          gstart_nxt = now_c;
        end
        if (win_clash || phase_r != PH_GESTURE) begin
          head_nxt  = tail_r;
          count_nxt = '0;
          phase_nxt = PH_IDLE;
          owner_nxt = '0;
          mods_nxt  = '0;
        end
        if (win_clash) begin
          vel_x_nxt = '0;
          vel_y_nxt = '0;
        end
        addr_nxt = ring_dec(tail_r);
        if (phase_r == PH_COAST) begin
          pend_nxt      = cancel_word;
          pend_nxt.last = 1'b0;
          ret_nxt       = S_SCALE;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_SCALE;
        end
      end

      S_SCALE: begin
        if (!in_r.raw_dy[31] && in_r.raw_dy != 32'sd0) begin
          div_num     = {{16{in_r.offset_y[31]}}, in_r.offset_y, 16'h0};
          div_den     = in_r.raw_dy;
          div_ret_nxt = S_SCALE_SET;
          go_div      = 1'b1;
        end else if (!in_r.raw_dx[31] && in_r.raw_dx != 32'sd0) begin
          div_num     = {{16{in_r.offset_x[31]}}, in_r.offset_x, 16'h0};
          div_den     = in_r.raw_dx;
          div_ret_nxt = S_SCALE_SET;
          go_div      = 1'b1;
        end else begin
          state_nxt = S_REV;
        end
      end

      S_SCALE_SET: begin
        scale_nxt = div_sat;
        state_nxt = S_REV;
      end

      // One restoring step per cycle; the dividend shifts out as the quotient shifts in.
      S_DIV: begin
        div_rem_nxt = rem_ge ? (rem_sh - {1'b0, div_d_r}) : rem_sh;
        div_q_nxt   = {div_q_r[62:0], rem_ge};
        if (div_cnt_r == '0) begin
          state_nxt = div_ret_r;
        end else begin
          div_cnt_nxt = div_cnt_r - 1'b1;
        end
      end

      // Reversal check, sample push and the coast decision.
      S_REV: begin
        if (reversal) begin
          vel_x_nxt = '0;
          vel_y_nxt = '0;
          cnt_v     = '0;
          head_v    = tail_r;
        end
        owner_nxt = in_r.window_tag;
        mods_nxt  = in_r.mod_keys;
        if (!synth) begin
          ram_we = 1'b1;
          if (cnt_v == HIST_CW'(HIST_DEPTH)) begin
            head_v = ring_inc(head_v);
          end else begin
            cnt_v = cnt_v + 1'b1;
          end
          tail_nxt = ring_inc(tail_r);
        end
        head_nxt  = head_v;
        count_nxt = cnt_v;
        if (in_r.stopped && coast_ok) begin
          phase_nxt = PH_COAST;
          start_nxt = 1'b1;
          state_nxt = S_TRIM;
        end else begin
          phase_nxt             = in_r.stopped ? PH_IDLE : PH_GESTURE;
          pend_nxt              = pass_word;
          pend_nxt.ticks_wanted = 1'b0;
          ret_nxt               = S_IDLE;
          state_nxt             = S_EMIT;
        end
      end

      // Drop samples older than the averaging window, oldest first.
      S_TRIM: begin
        if (count_r == '0) begin
          state_nxt = S_DECAY_X;
        end else begin
          addr_nxt  = head_r;
          state_nxt = S_TRIM_CHK;
        end
      end

      S_TRIM_CHK: begin
        if (age > TRIM_US) begin
          head_nxt  = ring_inc(head_r);
          count_nxt = count_r - 1'b1;
          state_nxt = S_TRIM;
        end else begin
          first_nxt = rd_t;
          addr_nxt  = ring_dec(tail_r);
          state_nxt = S_SPAN;
        end
      end

      S_SPAN: begin
        span_nxt  = (dspan == 32'd0) ? 32'd1 : dspan;
        idx_nxt   = head_r;
        addr_nxt  = head_r;
        cnt_nxt   = count_r;
        acc_x_nxt = '0;
        acc_y_nxt = '0;
        tw_nxt    = '0;
        state_nxt = S_W_RD;
      end

      S_W_RD: begin
        div_num     = {16'h0, sd, 16'h0};
        div_den     = span_r;
        div_ret_nxt = S_W_MX;
        go_div      = 1'b1;
      end

      S_W_MX: begin
        w_nxt     = w_c;
        tw_nxt    = tw_r + TW_W'(w_c);
        mul_a     = {rd_dx[31], rd_dx};
        mul_b     = {15'b0, w_c};
        state_nxt = S_W_MY;
      end

      S_W_MY: begin
        acc_x_nxt = acc_x_r + ACC_W'(prod_r);
        mul_a     = {rd_dy[31], rd_dy};
        mul_b     = {15'b0, w_r};
        state_nxt = S_W_ACC;
      end

      S_W_ACC: begin
        acc_y_nxt = acc_y_r + ACC_W'(prod_r);
        idx_nxt   = ring_inc(idx_r);
        addr_nxt  = ring_inc(idx_r);
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = (cnt_r == HIST_CW'(1)) ? S_VX : S_W_RD;
      end

      S_VX: begin
        div_num     = 64'(acc_x_r);
        div_den     = 32'(tw_r);
        div_ret_nxt = S_VY;
        go_div      = 1'b1;
      end

      S_VY: begin
        vel_x_nxt   = merge_axis(vel_x_r, div_sat, max_r);
        div_num     = 64'(acc_y_r);
        div_den     = 32'(tw_r);
        div_ret_nxt = S_VDONE;
        go_div      = 1'b1;
      end

      S_VDONE: begin
        vel_y_nxt = merge_axis(vel_y_r, div_sat, max_r);
        count_nxt = '0;
        head_nxt  = tail_r;
        state_nxt = S_DECAY_X;
      end

      // Friction, then the scaled copies, through the one multiplier.
      S_DECAY_X: begin
        mul_a     = {vel_x_r[31], vel_x_r};
        mul_b     = {16'b0, fric_eff};
        state_nxt = S_DECAY_Y;
      end

      S_DECAY_Y: begin
        vel_x_nxt = decay_axis(prod_r, min_r);
        mul_a     = {vel_y_r[31], vel_y_r};
        mul_b     = {16'b0, fric_eff};
        state_nxt = S_DECAY_DONE;
      end

      S_DECAY_DONE: begin
        vel_y_nxt = decay_axis(prod_r, min_r);
        mul_a     = {scale_r[31], scale_r};
        mul_b     = {vel_x_r[31], vel_x_r};
        state_nxt = S_SC_Y;
      end

      S_SC_Y: begin
        sx_nxt    = sat32(trunc_q16(prod_r));
        mul_a     = {scale_r[31], scale_r};
        mul_b     = {vel_y_r[31], vel_y_r};
        state_nxt = S_SC_DONE;
      end

      S_SC_DONE: begin
        if (ended) phase_nxt = PH_IDLE;
        pend_nxt.kind          = start_r ? KIND_BEGAN : (ended ? KIND_ENDED : KIND_ACTIVE);
        pend_nxt.vel_x         = vel_x_r;
        pend_nxt.vel_y         = vel_y_r;
        pend_nxt.scaled_x      = sx_r;
        pend_nxt.scaled_y      = sy_c;
        pend_nxt.target_window = owner_r;
        pend_nxt.out_mods      = mods_r;
        pend_nxt.ticks_wanted  = !ended;
        pend_nxt.last          = 1'b1;
        ret_nxt                = S_IDLE;
        state_nxt              = S_EMIT;
      end

      S_CANCEL: begin
        owner_nxt = '0;
        mods_nxt  = '0;
        count_nxt = '0;
        head_nxt  = tail_r;
        phase_nxt = PH_IDLE;
        vel_x_nxt = '0;
        vel_y_nxt = '0;
        if (phase_r == PH_COAST) begin
          pend_nxt  = cancel_word;
          ret_nxt   = S_IDLE;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ret_r;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (go_div) begin
      div_q_nxt   = div_num[63] ? 64'(-div_num) : 64'(div_num);
      div_neg_nxt = div_num[63];
      div_rem_nxt = '0;
      div_d_nxt   = div_den;
      div_cnt_nxt = DIV_CW'(DIV_STEPS - 1);
      state_nxt   = S_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fric_r <= FRIC_RESET;
      min_r  <= MIN_SPEED_RESET;
      max_r  <= MAX_SPEED_RESET;
      tmo_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRICTION:  fric_r <= cfg_wdata[16:0];
        CFG_MIN_SPEED: min_r  <= cfg_wdata;
        CFG_MAX_SPEED: max_r  <= cfg_wdata;
        CFG_TIMEOUT:   tmo_r  <= cfg_wdata[19:0];
        default:       tmo_r  <= tmo_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      vel_x_r     <= '0;
      vel_y_r     <= '0;
      scale_r     <= '0;
      owner_r     <= '0;
      mods_r      <= '0;
      gstart_r    <= '0;
      glen_r      <= '0;
      trav_x_r    <= '0;
      trav_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      vel_x_r  <= vel_x_nxt;
      vel_y_r  <= vel_y_nxt;
      scale_r  <= scale_nxt;
      owner_r  <= owner_nxt;
      mods_r   <= mods_nxt;
      gstart_r <= gstart_nxt;
      glen_r   <= glen_nxt;
      trav_x_r <= trav_x_nxt;
      trav_y_r <= trav_y_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ret_r     <= ret_nxt;
    in_r      <= in_nxt;
    now_r     <= now_nxt;
    addr_r    <= addr_nxt;
    first_r   <= first_nxt;
    span_r    <= span_nxt;
    idx_r     <= idx_nxt;
    cnt_r     <= cnt_nxt;
    w_r       <= w_nxt;
    acc_x_r   <= acc_x_nxt;
    acc_y_r   <= acc_y_nxt;
    tw_r      <= tw_nxt;
    start_r   <= start_nxt;
    sx_r      <= sx_nxt;
    pend_r    <= pend_nxt;
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    div_d_r   <= div_d_nxt;
    div_cnt_r <= div_cnt_nxt;
    div_neg_r <= div_neg_nxt;
    div_ret_r <= div_ret_nxt;
    prod_r    <= mul_a * mul_b;
    if (out_load) begin
      out_data_r <= pend_r;
    end
  end

  // The read address follows the sequencer's next address, so the data of
  // the entry chosen in one state is ready in the next.
  mse_ram #(
    .WIDTH(HIST_W),
    .DEPTH(HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdata),
    .raddr (addr_nxt),
    .rdata (ram_rdata)
  );

  a_hist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= HIST_CW'(HIST_DEPTH))
    else $error("history count beyond depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("engine took a second word without working on the first");

  a_cancel_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_CANCELED |->
      out_data.vel_x == 32'sd0 && out_data.vel_y == 32'sd0 && !out_data.ticks_wanted)
    else $error("canceled word carries motion");

  a_ended_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_ENDED |->
      out_data.vel_x == 32'sd0 && out_data.vel_y == 32'sd0 && !out_data.ticks_wanted)
    else $error("ended word with motion left");

endmodule
